@@ sv/trle_pkg.sv @@
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the threshold run-length encoder.
// ----------------------------------------------------------------------------
package trle_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_THRESHOLD      = 3'd0;
    localparam logic [2:0] REG_CHECK_MODE     = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_CHECK_LEVEL    = 3'd4;
    localparam logic [2:0] REG_SEGMENT_LENGTH = 3'd5;

    // stream constants
    localparam logic [7:0] HDR_A      = 8'h7A;
    localparam logic [7:0] HDR_B      = 8'h21;
    localparam logic [7:0] RUN_LIMIT  = 8'd190;
    localparam logic [7:0] MARK_BASE  = 8'd200;
    localparam logic [5:0] LEVEL_MAX  = 6'd55;

    // byte slots of one job, emitted from the lowest set slot upward
    localparam int NUM_SLOTS = 12;
    localparam logic [3:0] SLOT_SYNC_A   = 4'd0;
    localparam logic [3:0] SLOT_SYNC_B   = 4'd1;
    localparam logic [3:0] SLOT_WIDTH    = 4'd2;
    localparam logic [3:0] SLOT_HEIGHT   = 4'd3;
    localparam logic [3:0] SLOT_SYNC_A2  = 4'd4;
    localparam logic [3:0] SLOT_SYNC_B2  = 4'd5;
    localparam logic [3:0] SLOT_LEVEL    = 4'd6;
    localparam logic [3:0] SLOT_CHANGE   = 4'd7;
    localparam logic [3:0] SLOT_SEG_RUN  = 4'd8;
    localparam logic [3:0] SLOT_MARKER   = 4'd9;
    localparam logic [3:0] SLOT_LIMIT    = 4'd10;
    localparam logic [3:0] SLOT_FILL     = 4'd11;

    typedef struct packed {
        logic [7:0]  threshold;
        logic        check_mode;
        logic [7:0]  frame_width;
        logic [7:0]  frame_height;
        logic [5:0]  check_level;
        logic [15:0] segment_length;
    } t_cfg;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           change_run;
        logic [7:0]           seg_run;
        logic [7:0]           marker;
        logic [7:0]           limit_byte;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ sv/trle_cfg.sv @@
// ----------------------------------------------------------------------------
// trle_cfg
// APB-style register bank holding the encoder configuration.
// ----------------------------------------------------------------------------
module trle_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output trle_pkg::t_cfg      o_cfg
);
    import trle_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_index)
                REG_THRESHOLD:      n_cfg.threshold      = pwdata[7:0];
                REG_CHECK_MODE:     n_cfg.check_mode     = pwdata[0];
                REG_FRAME_WIDTH:    n_cfg.frame_width    = pwdata[7:0];
                REG_FRAME_HEIGHT:   n_cfg.frame_height   = pwdata[7:0];
                REG_CHECK_LEVEL:    n_cfg.check_level    = pwdata[5:0];
                REG_SEGMENT_LENGTH: n_cfg.segment_length = pwdata[15:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold      <= 8'd128;
            r_cfg.check_mode     <= 1'b0;
            r_cfg.frame_width    <= 8'd188;
            r_cfg.frame_height   <= 8'd120;
            r_cfg.check_level    <= 6'd10;
            r_cfg.segment_length <= 16'd2256;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read decode
    always_comb begin
        unique case (reg_index)
            REG_THRESHOLD:      prdata = {24'd0, r_cfg.threshold};
            REG_CHECK_MODE:     prdata = {31'd0, r_cfg.check_mode};
            REG_FRAME_WIDTH:    prdata = {24'd0, r_cfg.frame_width};
            REG_FRAME_HEIGHT:   prdata = {24'd0, r_cfg.frame_height};
            REG_CHECK_LEVEL:    prdata = {26'd0, r_cfg.check_level};
            REG_SEGMENT_LENGTH: prdata = {16'd0, r_cfg.segment_length};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/trle_front.sv @@
// ----------------------------------------------------------------------------
// trle_front
// Binarizes each pixel, tracks runs and segments, and turns the pixel into
// a job that lists the bytes to send.
// ----------------------------------------------------------------------------
module trle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trle_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  logic [7:0]          i_pixel,
    input  logic                i_frame_start,
    input  logic                i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output trle_pkg::t_job      o_job
);
    import trle_pkg::*;

    logic [7:0]  r_run;
    logic        r_prev;
    logic [15:0] r_spc;
    logic [7:0]  r_segn;
    logic [7:0]  n_run;
    logic        n_prev;
    logic [15:0] n_spc;
    logic [7:0]  n_segn;

    logic [7:0]  base_run;
    logic        base_prev;
    logic [15:0] base_spc;
    logic [7:0]  base_segn;
    logic        white;
    logic        change;
    logic [7:0]  run1;
    logic [15:0] spc1;
    logic [7:0]  segn1;
    logic        seg_end;
    logic [7:0]  run2;
    logic        limit;
    logic        accept;
    t_job        job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // state after an optional frame restart
    always_comb begin
        if (i_frame_start) begin
            base_run  = i_cfg.check_mode ? 8'd0 : 8'd1;
            base_prev = 1'b1;
            base_spc  = 16'd0;
            base_segn = 8'd0;
        end else begin
            base_run  = r_run;
            base_prev = r_prev;
            base_spc  = r_spc;
            base_segn = r_segn;
        end
    end

    // run and segment tracking
    always_comb begin
        white   = i_pixel > i_cfg.threshold;
        change  = white != base_prev;
        run1    = change ? 8'd1 : base_run + 8'd1;
        spc1    = base_spc + 16'd1;
        segn1   = base_segn + 8'd1;
        seg_end = i_cfg.check_mode && (spc1 == i_cfg.segment_length);
        run2    = seg_end ? 8'd0 : run1;
        limit   = run2 == RUN_LIMIT;

        job                     = '0;
        job.change_run          = base_run;
        job.seg_run             = run1;
        job.marker              = MARK_BASE + segn1;
        job.limit_byte          = i_cfg.check_mode ? RUN_LIMIT : RUN_LIMIT - 8'd1;
        job.mask[SLOT_SYNC_A]   = i_frame_start;
        job.mask[SLOT_SYNC_B]   = i_frame_start;
        job.mask[SLOT_WIDTH]    = i_frame_start;
        job.mask[SLOT_HEIGHT]   = i_frame_start;
        job.mask[SLOT_SYNC_A2]  = i_frame_start;
        job.mask[SLOT_SYNC_B2]  = i_frame_start;
        job.mask[SLOT_LEVEL]    = i_frame_start && i_cfg.check_mode;
        job.mask[SLOT_CHANGE]   = change;
        job.mask[SLOT_SEG_RUN]  = seg_end;
        job.mask[SLOT_MARKER]   = seg_end;
        job.mask[SLOT_LIMIT]    = limit;
        job.mask[SLOT_FILL]     = limit;

        if (i_cfg.check_mode) begin
            n_run  = limit ? 8'd0 : run2;
            n_prev = seg_end ? 1'b1 : white;
            n_spc  = seg_end ? 16'd0 : spc1;
            n_segn = seg_end ? segn1 : base_segn;
        end else begin
            n_run  = limit ? 8'd1 : run2;
            n_prev = white;
            n_spc  = base_spc;
            n_segn = base_segn;
        end
    end

    // jobs without bytes are dropped here
    assign o_push = accept && (job.mask != '0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 8'd1;
            r_prev <= 1'b1;
            r_spc  <= 16'd0;
            r_segn <= 8'd0;
        end else if (accept) begin
            r_run  <= n_run;
            r_prev <= n_prev;
            r_spc  <= n_spc;
            r_segn <= n_segn;
        end
    end

endmodule

@@ sv/trle_queue.sv @@
// ----------------------------------------------------------------------------
// trle_queue
// Short job queue between the pixel front end and the byte sequencer.
// ----------------------------------------------------------------------------
module trle_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  trle_pkg::t_job      i_job,
    input  logic                i_pop,
    output trle_pkg::t_job      o_head,
    output trle_pkg::t_q_status o_status
);
    import trle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == FULL_CNT;
    assign o_status.empty = r_count == '0;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/trle_back.sv @@
// ----------------------------------------------------------------------------
// trle_back
// Byte sequencer: walks the slots of each job and drives the output register.
// ----------------------------------------------------------------------------
module trle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trle_pkg::t_cfg      i_cfg,
    input  trle_pkg::t_job      i_head,
    input  logic                i_q_empty,
    output logic                o_pop,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);
    import trle_pkg::*;

    t_job                 r_job;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 out_free;
    logic                 active;
    logic                 emit;
    logic [3:0]           sel;
    logic [NUM_SLOTS-1:0] remaining;
    logic                 job_done;
    logic [5:0]           level;
    logic [7:0]           byte_sel;

    // lowest pending slot
    always_comb begin
        sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_job.mask[i]) begin
                sel = 4'(i);
            end
        end
        remaining = r_job.mask & ~(NUM_SLOTS'(1) << sel);
    end

    // byte for the chosen slot
    always_comb begin
        level = (i_cfg.check_level > LEVEL_MAX) ? LEVEL_MAX : i_cfg.check_level;
        case (sel) inside
            SLOT_SYNC_A, SLOT_SYNC_A2: byte_sel = HDR_A;
            SLOT_SYNC_B, SLOT_SYNC_B2: byte_sel = HDR_B;
            SLOT_WIDTH:                byte_sel = i_cfg.frame_width;
            SLOT_HEIGHT:               byte_sel = i_cfg.frame_height;
            SLOT_LEVEL:                byte_sel = MARK_BASE + {2'b00, level};
            SLOT_CHANGE:               byte_sel = r_job.change_run;
            SLOT_SEG_RUN:              byte_sel = r_job.seg_run;
            SLOT_MARKER:               byte_sel = r_job.marker;
            SLOT_LIMIT:                byte_sel = r_job.limit_byte;
            default:                   byte_sel = 8'd0;
        endcase
    end

    // flow control: load the next job as the current one sends its last byte, or while no job is active
    assign out_free = !r_out_valid || i_m_tready;
    assign active   = r_job.mask != '0;
    assign emit     = out_free && active;
    assign job_done = !active || (emit && (remaining == '0));
    assign o_pop    = job_done && !i_q_empty;

    // current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job <= '0;
        end else if (o_pop) begin
            r_job <= i_head;
        end else if (emit) begin
            r_job.mask <= remaining;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_sel;
            r_out_last <= remaining == '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

@@ sv/threshold_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// threshold_run_length_encoder
// Binarizes grey pixels and codes them as a framed run-length byte stream.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while the job queue has room. Each pixel
// that produces bytes becomes one job; the sequencer sends one byte per clock
// while the sink accepts, so an ordinary pixel yields at most two bytes (a run
// split), a frame-start pixel 6 to 10 and a segment-end pixel up to 3. The
// QUEUE_DEPTH-entry job queue absorbs these bursts; input stalls only when the
// queue is full, that is when the downstream sink is slower than the byte rate
// the image produces. Each job passes the queue, the sequencer's job register
// and the output register; the run open at the end of a frame is not flushed.
module threshold_run_length_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] pixel
    input  logic        i_s_tuser,   // [0] frame_start
    // byte stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,   // last byte of a pixel
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import trle_pkg::*;

    t_cfg      cfg;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // register bank
    trle_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pixel classification
    trle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_s_tvalid),
        .i_pixel       (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .i_q_full      (q_status.full),
        .o_ready       (o_s_tready),
        .o_push        (push),
        .o_job         (push_job)
    );

    // job queue
    trle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // byte sequencer
    trle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head_job),
        .i_q_empty  (q_status.empty),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef NO_ASSERTIONS
    // no job is written into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    // no job is taken from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // the queue cannot be full and empty at once
    a_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // nothing is presented right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
